[hw/rtl/rld_pkg.sv]
// Shared opcodes and color codes for the RGB LED dimmer.
`default_nettype none

package rld_pkg;

    typedef enum logic [1:0] {
        OP_KNOB  = 2'd0,
        OP_MODE  = 2'd1,
        OP_COLOR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam int unsigned NUM_COLORS = 3;

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    localparam int unsigned WINDOW_RESET = 5;

endpackage

`default_nettype wire

[hw/rtl/rld_scale.sv]
// Scales a saved level by the knob: floor(saved * knob / (2^LEVEL_BITS - 1)).
`default_nettype none

module rld_scale #(
    parameter int unsigned LEVEL_BITS = 10
) (
    input  wire logic [LEVEL_BITS-1:0] saved,
    input  wire logic [LEVEL_BITS-1:0] knob,
    output logic      [LEVEL_BITS-1:0] duty
);

    localparam int unsigned PW = 2 * LEVEL_BITS;

    logic [PW-1:0] prod;
    logic [PW-1:0] adj;

    // Divide by 2^L-1: add the high half plus one, then take the high half.
    // The product never exceeds (2^L-1)^2, so the sum stays below 2^(2L).
    assign prod = PW'(saved) * PW'(knob);
    assign adj  = prod + PW'(prod[PW-1:LEVEL_BITS]) + PW'(1);
    assign duty = adj[PW-1:LEVEL_BITS];

endmodule

`default_nettype wire

[hw/rtl/rgb_led_dimmer_with_pot_takeover.sv]
// Top level of the three-channel LED dimmer with knob takeover.
// Path: an accepted item waits in the input register, then moves into the state registers, which
//   drive m_tvalid and m_tdata; a stalled result keeps the next item waiting in the input register.
// Throughput: one item per cycle unless a result stalls; s_tready follows m_tready
//   combinationally once both the input register and the result register hold items.
// Reset: synchronous, active low; clears mode, color, levels, pickup and the valid bits,
//   and sets the pickup window to 5.
`default_nettype none

module rgb_led_dimmer_with_pot_takeover #(
    parameter int unsigned LEVEL_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [LEVEL_BITS-1:0] cfg_wdata,   // pickup_window

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [LEVEL_BITS-1:0] knob_level, zero fill above
    input  wire logic [((LEVEL_BITS+7)/8)*8-1:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]            s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // red_duty, green_duty, blue_duty (LEVEL_BITS each), single_mode, current_color[1:0],
    // picked_up, zero fill above
    output logic [((3*LEVEL_BITS+4+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned NC    = rld_pkg::NUM_COLORS;
    localparam int unsigned OUT_W = ((3*LEVEL_BITS+4+7)/8)*8;
    localparam int unsigned USED  = 3*LEVEL_BITS + 4;

    logic                  in_valid_reg;
    rld_pkg::opcode_t      in_op_reg;
    logic [LEVEL_BITS-1:0] in_knob_reg;
    logic                  out_valid_reg;

    logic [LEVEL_BITS-1:0] win_reg;
    logic                  mode_reg,  mode_next;
    logic [1:0]            color_reg, color_next;
    logic                  pick_reg,  pick_next;
    logic [LEVEL_BITS-1:0] saved_reg [NC];
    logic [LEVEL_BITS-1:0] saved_next[NC];
    logic [LEVEL_BITS-1:0] duty_reg  [NC];
    logic [LEVEL_BITS-1:0] duty_next [NC];

    logic [LEVEL_BITS-1:0] scaled [NC];
    logic [LEVEL_BITS-1:0] act_saved;
    logic [LEVEL_BITS-1:0] diff;
    logic                  advance;

    // Move the held item into the state when the result slot is free or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= rld_pkg::opcode_t'(s_tuser);
            in_knob_reg <= s_tdata[LEVEL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= LEVEL_BITS'(rld_pkg::WINDOW_RESET);
        end else if (cfg_we) begin
            win_reg <= cfg_wdata;
        end
    end

    for (genvar c = 0; c < NC; c++) begin : g_lane
        rld_scale #(.LEVEL_BITS(LEVEL_BITS)) u_scale (
            .saved (saved_reg[c]),
            .knob  (in_knob_reg),
            .duty  (scaled[c])
        );
    end

    assign act_saved = saved_reg[color_reg];
    assign diff      = (in_knob_reg >= act_saved) ? (in_knob_reg - act_saved)
                                                  : (act_saved - in_knob_reg);

    always_comb begin
        mode_next  = mode_reg;
        color_next = color_reg;
        pick_next  = pick_reg;
        for (int c = 0; c < NC; c++) begin
            saved_next[c] = saved_reg[c];
            duty_next[c]  = duty_reg[c];
        end
        unique case (in_op_reg)
            rld_pkg::OP_KNOB: begin
                if (!mode_reg) begin
                    for (int c = 0; c < NC; c++) begin
                        duty_next[c] = scaled[c];
                    end
                end else begin
                    for (int c = 0; c < NC; c++) begin
                        duty_next[c] = '0;
                    end
                    duty_next[color_reg] = pick_reg ? in_knob_reg : act_saved;
                    if (!pick_reg && (diff < win_reg)) begin
                        pick_next = 1'b1;
                    end
                    // An unset level takes the first knob reading.
                    if (act_saved == '0) begin
                        saved_next[color_reg] = in_knob_reg;
                    end
                end
            end
            rld_pkg::OP_MODE: begin
                mode_next = !mode_reg;
                pick_next = 1'b0;
            end
            rld_pkg::OP_COLOR: begin
                if (mode_reg) begin
                    saved_next[color_reg] = duty_reg[color_reg];
                    color_next = (color_reg == rld_pkg::COLOR_BLUE) ? rld_pkg::COLOR_RED
                                                                    : color_reg + 2'd1;
                    pick_next  = 1'b0;
                end
            end
            rld_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            color_reg <= rld_pkg::COLOR_RED;
            pick_reg  <= 1'b0;
            for (int c = 0; c < NC; c++) begin
                saved_reg[c] <= '0;
                duty_reg[c]  <= '0;
            end
        end else if (advance) begin
            mode_reg  <= mode_next;
            color_reg <= color_next;
            pick_reg  <= pick_next;
            for (int c = 0; c < NC; c++) begin
                saved_reg[c] <= saved_next[c];
                duty_reg[c]  <= duty_next[c];
            end
        end
    end

    // The state registers hold still while a result waits, so they are the result.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W-USED)'(0), pick_reg, color_reg, mode_reg,
                       duty_reg[2], duty_reg[1], duty_reg[0]};

endmodule

`default_nettype wire

[hw/rtl/rld_checker.sv]
// Port-level checks for the LED dimmer, bound to the top level.
`default_nettype none

module rld_checker #(
    parameter int unsigned LEVEL_BITS = 10
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [((3*LEVEL_BITS+4+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned MODE_BIT = 3 * LEVEL_BITS;
    localparam int unsigned PICK_BIT = 3 * LEVEL_BITS + 3;

    logic       mode_bit;
    logic       pick_bit;
    logic [1:0] color_bits;

    assign mode_bit   = m_tdata[MODE_BIT];
    assign pick_bit   = m_tdata[PICK_BIT];
    assign color_bits = m_tdata[MODE_BIT+2:MODE_BIT+1];

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_color_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (color_bits == rld_pkg::COLOR_RED) ||
                     (color_bits == rld_pkg::COLOR_GREEN) ||
                     (color_bits == rld_pkg::COLOR_BLUE))
        else $error("active color out of range");

    a_no_pickup_blended: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !mode_bit |-> !pick_bit)
        else $error("pickup set in blended mode");

endmodule

bind rgb_led_dimmer_with_pot_takeover rld_checker #(.LEVEL_BITS(LEVEL_BITS)) u_rld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
